// ===== design/lpd_pkg.sv =====
// Shared types and constants for the length-prefix packet deframer.
package lpd_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned PUSH_MAX     = 4;

  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  localparam logic RK_PKT = 1'b0;
  localparam logic RK_ERR = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_POISON  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
    logic       kind;
  } res_t;

  // up to four results enter the result queue per accepted byte
  typedef struct packed {
    logic [2:0]     n;
    res_t [3:0]     ent;
  } push_t;

endpackage

// ===== design/lpd_res_fifo.sv =====
// Result queue: shift-style FIFO that takes up to four results per cycle.
module lpd_res_fifo #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned CNT_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lpd_pkg::push_t    push,
  input  logic              pop,
  output lpd_pkg::res_t     head,
  output logic [CNT_W-1:0]  cnt
);

  lpd_pkg::res_t    q_r   [DEPTH];
  lpd_pkg::res_t    q_nxt [DEPTH];
  lpd_pkg::res_t    sh    [DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] push_n;

  assign push_n = CNT_W'(push.n);
  assign base   = cnt_r - CNT_W'(pop);

  always_comb begin
    logic [CNT_W-1:0] off;
    off = '0;
    for (int i = 0; i < DEPTH - 1; i++) begin
      sh[i] = pop ? q_r[i+1] : q_r[i];
    end
    sh[DEPTH-1] = q_r[DEPTH-1];
    for (int i = 0; i < DEPTH; i++) begin
      off      = CNT_W'(i) - base;
      q_nxt[i] = sh[i];
      if ((CNT_W'(i) >= base) && (off < push_n)) begin
        q_nxt[i] = push.ent[off[1:0]];
      end
    end
    cnt_nxt = base + push_n;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head = q_r[0];
  assign cnt  = cnt_r;

endmodule

// ===== design/length_prefix_packet_deframer.sv =====
// Top level of the length-prefix packet deframer.
// Cuts a byte stream into packets with a 4-byte header (opcode, then payload
// length, both little-endian) and returns header and payload bytes in order,
// the last byte of each packet flagged. One input byte is taken per cycle;
// each byte's work is done in the cycle it is accepted and its results land in
// a FIFO_DEPTH-entry result queue that drains one result per cycle. The fourth
// header byte may place all four header bytes in the queue at once, so the
// input stalls only when the queue lacks room for the results the next byte
// may cause (four in that slot, one otherwise); with the default depth and an
// unstalled output the block sustains one byte per cycle. A length above
// max_payload_length gives one error result, after which every byte is
// swallowed until reset. The configuration port is always ready.
module length_prefix_packet_deframer #(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_is_last,
  output logic        out_result_kind,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_payload_length
);

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  lpd_pkg::phase_t  phase_r, phase_nxt;
  logic [1:0]       hc_r, hc_nxt;
  logic [7:0]       held_r [lpd_pkg::HEADER_BYTES-1];
  logic [15:0]      left_r, left_nxt;
  logic [15:0]      max_len_r;
  logic [15:0]      len;
  logic [15:0]      left_dec;
  logic             in_fire;
  logic             hdr_last;
  logic [CNT_W-1:0] need;
  logic [CNT_W-1:0] fifo_cnt;
  lpd_pkg::push_t   push;
  lpd_pkg::res_t    head;

  assign in_fire  = in_valid && !in_stall;
  assign hdr_last = (phase_r == lpd_pkg::PH_HEADER) && (hc_r == 2'd3);
  assign len      = {in_data_byte, held_r[2]};
  assign left_dec = left_r - 16'd1;

  // room for the worst case this byte can cause
  assign need     = hdr_last ? CNT_W'(lpd_pkg::PUSH_MAX) : CNT_W'(1);
  assign in_stall = fifo_cnt > (CNT_W'(FIFO_DEPTH) - need);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    left_nxt  = left_r;
    if (in_fire) begin
      case (phase_r)
        lpd_pkg::PH_HEADER: begin
          if (hc_r != 2'd3) begin
            hc_nxt = hc_r + 2'd1;
          end else begin
            hc_nxt = 2'd0;
            if (len > max_len_r) begin
              phase_nxt = lpd_pkg::PH_POISON;
            end else if (len != 16'd0) begin
              phase_nxt = lpd_pkg::PH_PAYLOAD;
              left_nxt  = len;
            end
          end
        end
        lpd_pkg::PH_PAYLOAD: begin
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt = lpd_pkg::PH_HEADER;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // results
  always_comb begin
    push = '0;
    if (in_fire) begin
      case (phase_r)
        lpd_pkg::PH_HEADER: begin
          if (hc_r == 2'd3) begin
            if (len > max_len_r) begin
              push.n      = 3'd1;
              push.ent[0] = '{data: 8'd0, is_last: 1'b0, kind: lpd_pkg::RK_ERR};
            end else begin
              push.n      = 3'd4;
              push.ent[0] = '{data: held_r[0], is_last: 1'b0, kind: lpd_pkg::RK_PKT};
              push.ent[1] = '{data: held_r[1], is_last: 1'b0, kind: lpd_pkg::RK_PKT};
              push.ent[2] = '{data: held_r[2], is_last: 1'b0, kind: lpd_pkg::RK_PKT};
              push.ent[3] = '{data: in_data_byte, is_last: (len == 16'd0),
                              kind: lpd_pkg::RK_PKT};
            end
          end
        end
        lpd_pkg::PH_PAYLOAD: begin
          push.n      = 3'd1;
          push.ent[0] = '{data: in_data_byte, is_last: (left_dec == 16'd0),
                          kind: lpd_pkg::RK_PKT};
        end
        default: begin
          push.n = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lpd_pkg::PH_HEADER;
      hc_r      <= 2'd0;
      left_r    <= 16'd0;
      max_len_r <= lpd_pkg::MAX_LEN_RESET;
    end else begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      left_r  <= left_nxt;
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_max_payload_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (phase_r == lpd_pkg::PH_HEADER) && (hc_r != 2'd3)) begin
      held_r[hc_r] <= in_data_byte;
    end
  end

  lpd_res_fifo #(
    .DEPTH (FIFO_DEPTH),
    .CNT_W (CNT_W)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_valid && !out_stall),
    .head  (head),
    .cnt   (fifo_cnt)
  );

  assign out_valid       = fifo_cnt != '0;
  assign out_byte        = head.data;
  assign out_is_last     = head.is_last;
  assign out_result_kind = head.kind;

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_poison_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lpd_pkg::PH_POISON) |-> (push.n == 3'd0))
    else $error("request produced results while poisoned");

  a_err_poisons: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 3'd1 && push.ent[0].kind == lpd_pkg::RK_ERR) |=>
    (phase_r == lpd_pkg::PH_POISON))
    else $error("error result without poisoning");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lpd_pkg::PH_PAYLOAD) |-> (left_r != 16'd0 && hc_r == 2'd0))
    else $error("payload phase with no bytes left");
`endif

endmodule

// ===== bench/length_prefix_packet_deframer_tb.sv =====
// Self-checking bench for the length-prefix packet deframer: random byte streams vs. a predictor.
module length_prefix_packet_deframer_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_is_last;
  logic        out_result_kind;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_max_payload_length = 16'h0000;

  length_prefix_packet_deframer uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_data_byte           (in_data_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_byte               (out_byte),
    .out_is_last            (out_is_last),
    .out_result_kind        (out_result_kind),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_max_payload_length (cfg_max_payload_length)
  );

  always #4 clk = ~clk;

  // stimulus and expected results
  logic [7:0]      pending_bytes [$];
  lpd_pkg::res_t   expected_out [$];
  int unsigned     queued_cnt = 0;
  int unsigned     accepted_cnt = 0;
  int unsigned     mismatches = 0;

  // pacing controls; idle_on and hold_go are written by the sequencer at clock edges, the rest by the pacing blocks
  logic        idle_on = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;

  // deframer state as the bench sees it
  lpd_pkg::phase_t ph = lpd_pkg::PH_HEADER;
  logic [1:0]      hdr_cnt = 2'd0;
  logic [7:0]      hdr_hold [lpd_pkg::HEADER_BYTES - 1];
  logic [15:0]     left = 16'd0;
  logic [15:0]     max_len = lpd_pkg::MAX_LEN_RESET;

  function automatic lpd_pkg::res_t mk_res(input logic [7:0] b, input logic lst, input logic k);
    lpd_pkg::res_t r;
    r.data = b;
    r.is_last = lst;
    r.kind = k;
    return r;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [15:0] len;
    len = {b, hdr_hold[2]};
    case (ph)
      lpd_pkg::PH_HEADER: begin
        if (hdr_cnt < lpd_pkg::HEADER_BYTES - 1) begin
          hdr_hold[hdr_cnt] = b;
          hdr_cnt = hdr_cnt + 2'd1;
        end else begin
          hdr_cnt = 2'd0;
          if (len > max_len) begin
            ph = lpd_pkg::PH_POISON;
            expected_out.push_back(mk_res(8'h00, 1'b0, lpd_pkg::RK_ERR));
          end else begin
            expected_out.push_back(mk_res(hdr_hold[0], 1'b0, lpd_pkg::RK_PKT));
            expected_out.push_back(mk_res(hdr_hold[1], 1'b0, lpd_pkg::RK_PKT));
            expected_out.push_back(mk_res(hdr_hold[2], 1'b0, lpd_pkg::RK_PKT));
            expected_out.push_back(mk_res(b, len == 16'd0, lpd_pkg::RK_PKT));
            if (len != 16'd0) begin
              left = len;
              ph = lpd_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      lpd_pkg::PH_PAYLOAD: begin
        left = left - 16'd1;
        expected_out.push_back(mk_res(b, left == 16'd0, lpd_pkg::RK_PKT));
        if (left == 16'd0) ph = lpd_pkg::PH_HEADER;
      end
      default: ; // poisoned: swallowed
    endcase
  endfunction

  function automatic void log_mismatch(input string what, input lpd_pkg::res_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want byte=%02h last=%b kind=%b, got byte=%02h last=%b kind=%b",
               $time, what, want.data, want.is_last, want.kind,
               out_byte, out_is_last, out_result_kind);
  endfunction

  // driver: one byte per request, random gap after each accepted one while idle_on is set and no hold-off runs
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) tx_gap = (idle_on && hold_cnt == 0) ? $urandom_range(0, 12) : 0;
      if (tx_gap != 0) begin
        tx_gap = tx_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_valid <= 1'b1;
        in_data_byte <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, armed once by the sequencer
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 120;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor: predict on input requests, check output requests, drive out_stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_data_byte);
        accepted_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0)
          log_mismatch("unexpected result", mk_res(8'h00, 1'b0, lpd_pkg::RK_PKT));
        else if (out_byte !== expected_out[0].data || out_is_last !== expected_out[0].is_last ||
                 out_result_kind !== expected_out[0].kind)
          log_mismatch("mismatch", expected_out[0]);
        if (expected_out.size() != 0) void'(expected_out.pop_front());
        rx_wait = idle_on ? $urandom_range(0, 12) : 0;
      end else if (rx_wait != 0) begin
        rx_wait = rx_wait - 1;
      end
      out_stall <= (rx_wait != 0) || (hold_cnt != 0);
    end
  end

  function automatic void queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_cnt++;
  endfunction

  function automatic void queue_header(input logic [15:0] op, input logic [15:0] len);
    queue_byte(op[7:0]);
    queue_byte(op[15:8]);
    queue_byte(len[7:0]);
    queue_byte(len[15:8]);
  endfunction

  function automatic void queue_packet(input logic [15:0] op, input logic [15:0] len);
    int unsigned i;
    queue_header(op, len);
    for (i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic int unsigned pick_len(input int unsigned lim);
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 9);
    if (r < 2) len = 0;
    else if (r < 8) len = $urandom_range(1, 12);
    else len = $urandom_range(13, 60);
    return (len > lim) ? lim : len;
  endfunction

  task automatic wait_accepted();
    do @(posedge clk); while (accepted_cnt != queued_cnt);
  endtask

  // idle point: every byte taken and every result seen, then let the pipe settle
  task automatic wait_drained();
    do @(posedge clk); while (accepted_cnt != queued_cnt || expected_out.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_payload_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_len = v;
  endtask

  initial begin
    int unsigned k;
    int unsigned n;
    int unsigned len;
    logic [15:0] m;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on <= 1'b1;

    // default limit, payload bytes at both extremes
    queue_header(16'h1234, 16'd2);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    wait_drained();

    // zero limit: only empty packets pass, last flag on the length byte
    write_max_len(16'd0);
    queue_header(16'h0000, 16'd0);
    queue_header(16'hFFFF, 16'd0);
    wait_drained();

    // length equal to the limit, then a one-byte payload
    write_max_len(16'd3);
    queue_header(16'hA55A, 16'd3);
    queue_byte(8'h80);
    queue_byte(8'h01);
    queue_byte(8'h7E);
    queue_header(16'h00FF, 16'd1);
    queue_byte(8'hC3);
    wait_drained();

    for (k = 0; k < 5; k++) begin
      case (k)
        0: m = 16'hFFFF;
        1: m = 16'd17;
        2: m = 16'd0;
        3: m = 16'($urandom_range(1, 64));
        default: m = lpd_pkg::MAX_LEN_RESET;
      endcase
      write_max_len(m);
      @(posedge clk);
      idle_on <= (k != 0);
      if (k == 4) hold_go <= 1'b1;
      n = 0;
      while (n < 50) begin
        len = pick_len(32'(m));
        queue_packet(16'($urandom_range(0, 65535)), 16'(len));
        n += lpd_pkg::HEADER_BYTES + len;
      end
      wait_drained();
    end

    // just over the limit poisons the stream; later bytes vanish
    write_max_len(16'hFFFE);
    @(posedge clk);
    idle_on <= 1'b1;
    queue_packet(16'($urandom_range(0, 65535)), 16'd5);
    queue_header(16'($urandom_range(0, 65535)), 16'hFFFF);
    for (k = 0; k < 12; k++) queue_byte(8'($urandom_range(0, 255)));
    wait_accepted();

    k = 0;
    while (expected_out.size() != 0 && k < 4000) begin
      @(posedge clk);
      k++;
    end
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_out.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
